### design/hwpid_pkg.sv
// Shared types, constants and microprogram for the heater warm-up PID controller.
package hwpid_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PREHEAT_TICKS  = 3'd0;
  localparam logic [2:0] REG_OPER_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_HEATER_TARGET  = 3'd2;
  localparam logic [2:0] REG_GAIN_P         = 3'd3;
  localparam logic [2:0] REG_GAIN_I         = 3'd4;
  localparam logic [2:0] REG_GAIN_D         = 3'd5;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd6;
  localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd7;

  // Warm-up phases
  localparam logic [1:0] PH_PREHEAT = 2'd0;
  localparam logic [1:0] PH_RAMPUP  = 2'd1;
  localparam logic [1:0] PH_HEATUP  = 2'd2;
  localparam logic [1:0] PH_OPER    = 2'd3;

  // Fixed drive levels
  localparam logic [14:0] PREHEAT_DRIVE = 15'd2000;
  localparam logic [14:0] RAMP_START    = 15'd8000;
  localparam logic [14:0] RAMP_END      = 15'd12000;
  localparam logic [14:0] RAMP_STEP     = 15'd4;
  localparam logic [15:0] DUTY_FULL     = 16'hffff;

  // Quotient bits produced by the serial divider
  localparam logic [4:0] DIV_BITS = 5'd31;

  // Microcode operations
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_PHASE   = 4'd2;
  localparam logic [3:0] OP_ESUM    = 4'd3;
  localparam logic [3:0] OP_CLAMP   = 4'd4;
  localparam logic [3:0] OP_MULI    = 4'd5;
  localparam logic [3:0] OP_MULD    = 4'd6;
  localparam logic [3:0] OP_SUM     = 4'd7;
  localparam logic [3:0] OP_LIMIT   = 4'd8;
  localparam logic [3:0] OP_DUTYMUL = 4'd9;
  localparam logic [3:0] OP_DIVINIT = 4'd10;
  localparam logic [3:0] OP_DIV     = 4'd11;
  localparam logic [3:0] OP_DUTY    = 4'd12;
  localparam logic [3:0] OP_OUT     = 4'd13;

  // Stall conditions: the step holds and does nothing while true
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_NOIN    = 2'd1;
  localparam logic [1:0] ST_OUTBUSY = 2'd2;

  // Jump conditions: go to the target when true, else to the next step
  localparam logic [1:0] JP_NONE    = 2'd0;
  localparam logic [1:0] JP_ALWAYS  = 2'd1;
  localparam logic [1:0] JP_NOPID   = 2'd2;
  localparam logic [1:0] JP_DIVMORE = 2'd3;

  // Program labels
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] PC_PHASE   = 4'd1;
  localparam logic [PC_W-1:0] PC_ESUM    = 4'd2;
  localparam logic [PC_W-1:0] PC_CLAMP   = 4'd3;
  localparam logic [PC_W-1:0] PC_MULI    = 4'd4;
  localparam logic [PC_W-1:0] PC_MULD    = 4'd5;
  localparam logic [PC_W-1:0] PC_SUM     = 4'd6;
  localparam logic [PC_W-1:0] PC_LIMIT   = 4'd7;
  localparam logic [PC_W-1:0] PC_DUTYMUL = 4'd8;
  localparam logic [PC_W-1:0] PC_DIVINIT = 4'd9;
  localparam logic [PC_W-1:0] PC_DIV     = 4'd10;
  localparam logic [PC_W-1:0] PC_DUTY    = 4'd11;
  localparam logic [PC_W-1:0] PC_OUT     = 4'd12;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      stall;
    logic [1:0]      jump;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Control store: one control word per step
  function automatic ctrl_word_t micro_rom(logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, stall: ST_NONE, jump: JP_ALWAYS, target: PC_WAIT};
    case (pc)
      PC_WAIT:    cw = '{op: OP_LOAD,    stall: ST_NOIN,    jump: JP_NONE,    target: PC_WAIT};
      PC_PHASE:   cw = '{op: OP_PHASE,   stall: ST_NONE,    jump: JP_NOPID,   target: PC_DUTYMUL};
      PC_ESUM:    cw = '{op: OP_ESUM,    stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_CLAMP:   cw = '{op: OP_CLAMP,   stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_MULI:    cw = '{op: OP_MULI,    stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_MULD:    cw = '{op: OP_MULD,    stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_SUM:     cw = '{op: OP_SUM,     stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_LIMIT:   cw = '{op: OP_LIMIT,   stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_DUTYMUL: cw = '{op: OP_DUTYMUL, stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_DIVINIT: cw = '{op: OP_DIVINIT, stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_DIV:     cw = '{op: OP_DIV,     stall: ST_NONE,    jump: JP_DIVMORE, target: PC_DIV};
      PC_DUTY:    cw = '{op: OP_DUTY,    stall: ST_NONE,    jump: JP_NONE,    target: PC_WAIT};
      PC_OUT:     cw = '{op: OP_OUT,     stall: ST_OUTBUSY, jump: JP_ALWAYS,  target: PC_WAIT};
      default:    cw = '{op: OP_NOP,     stall: ST_NONE,    jump: JP_ALWAYS,  target: PC_WAIT};
    endcase
    return cw;
  endfunction

endpackage

### design/heater_warmup_pid_controller_unit.sv
// Heater warm-up sequencer with PID regulation and PWM duty computation.
//
// One input transaction is one 10 ms tick (sensor reading, battery voltage) and
// yields one result transaction (phase, heater drive, inverted PWM duty). A
// microcoded sequencer walks a 13-step program over a datapath with one shared
// 17x17 signed multiplier and a one-bit-per-cycle restoring divider. A tick in
// heat-up or operational runs all 13 steps; a tick in preheat or ramp-up skips
// the six PID steps. Most of a tick's time goes to the divider iterations for
// the duty quotient. The sequencer takes a new tick only once it is back at its
// load step after presenting the previous result. The result sits in an output
// register, so the next tick is accepted while it waits; the sequencer only
// holds at its last step if the previous result is still untaken. Configuration
// registers are written through a plain write port; a write takes effect at
// once, also on a tick that is in progress.
module heater_warmup_pid_controller_unit
  import hwpid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // tick input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] sensor_reading_i,
  input  logic [14:0] battery_voltage_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  phase_o,
  output logic [14:0] heater_drive_o,
  output logic [15:0] pwm_duty_o
);

  // Configuration registers
  logic [15:0]        preheat_ticks_q;
  logic [11:0]        oper_threshold_q;
  logic [11:0]        heater_target_q;
  logic signed [15:0] gain_p_q;
  logic signed [15:0] gain_i_q;
  logic signed [15:0] gain_d_q;
  logic [14:0]        integral_limit_q;
  logic [14:0]        drive_limit_q;

  // Sequencer and architectural state
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [1:0]         phase_q, phase_d;
  logic [15:0]        preheat_count_q, preheat_count_d;
  logic [14:0]        drive_q, drive_d;
  logic signed [15:0] error_sum_q, error_sum_d;
  logic signed [12:0] prev_error_q, prev_error_d;
  logic               out_valid_q, out_valid_d;

  // Datapath working registers
  logic [11:0]        reading_q, reading_d;
  logic [14:0]        vbat_q, vbat_d;
  logic signed [12:0] err_q, err_d;
  logic signed [13:0] dif_q, dif_d;
  logic signed [16:0] raw_sum_q, raw_sum_d;
  logic signed [33:0] prod_q, prod_d;
  logic signed [33:0] acc_q, acc_d;
  logic [30:0]        num_q, num_d;
  logic [14:0]        rem_q, rem_d;
  logic [4:0]         div_cnt_q, div_cnt_d;
  logic [15:0]        duty_q, duty_d;
  logic [1:0]         phase_out_q, phase_out_d;
  logic [14:0]        drive_out_q, drive_out_d;
  logic [15:0]        duty_out_q, duty_out_d;

  // Control and helper signals
  ctrl_word_t         cw;
  logic               stalled;
  logic               jump_taken;
  logic               exec;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic [16:0]        div_trial;
  logic signed [16:0] lim_pos, lim_neg;
  logic signed [33:0] drive_lim_ext;

  // Fetch the control word and resolve stall and jump
  always_comb begin
    cw = micro_rom(pc_q);
    case (cw.stall)
      ST_NOIN:    stalled = !in_valid_i;
      ST_OUTBUSY: stalled = out_valid_q && !out_ready_i;
      default:    stalled = 1'b0;
    endcase
    case (cw.jump)
      JP_ALWAYS:  jump_taken = 1'b1;
      JP_NOPID:   jump_taken = !phase_q[1];
      JP_DIVMORE: jump_taken = (div_cnt_q != 5'd1);
      default:    jump_taken = 1'b0;
    endcase
    exec = !stalled;
    if (stalled) begin
      pc_d = pc_q;
    end else if (jump_taken) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  assign in_ready_o = (cw.op == OP_LOAD);

  // Select the shared multiplier operands
  always_comb begin
    case (cw.op)
      OP_CLAMP: begin
        mul_a = {gain_p_q[15], gain_p_q};
        mul_b = {{4{err_q[12]}}, err_q};
      end
      OP_MULI: begin
        mul_a = {gain_i_q[15], gain_i_q};
        mul_b = {error_sum_d[15], error_sum_d};
      end
      OP_MULD: begin
        mul_a = {gain_d_q[15], gain_d_q};
        mul_b = {{3{dif_q[13]}}, dif_q};
      end
      OP_DUTYMUL: begin
        mul_a = {1'b0, DUTY_FULL};
        mul_b = {2'b00, drive_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Helpers for clamps and the divider step
  assign lim_pos       = $signed({2'b00, integral_limit_q});
  assign lim_neg       = -lim_pos;
  assign drive_lim_ext = $signed({19'd0, drive_limit_q});
  assign div_trial     = {1'b0, rem_q, num_q[30]} - {2'b00, vbat_q};

  // Execute the current step
  always_comb begin
    phase_d         = phase_q;
    preheat_count_d = preheat_count_q;
    drive_d         = drive_q;
    error_sum_d     = error_sum_q;
    prev_error_d    = prev_error_q;
    reading_d       = reading_q;
    vbat_d          = vbat_q;
    err_d           = err_q;
    dif_d           = dif_q;
    raw_sum_d       = raw_sum_q;
    prod_d          = prod_q;
    acc_d           = acc_q;
    num_d           = num_q;
    rem_d           = rem_q;
    div_cnt_d       = div_cnt_q;
    duty_d          = duty_q;
    phase_out_d     = phase_out_q;
    drive_out_d     = drive_out_q;
    duty_out_d      = duty_out_q;
    out_valid_d     = out_valid_q;

    // drop the result once taken
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (exec) begin
      case (cw.op)
        OP_LOAD: begin
          reading_d = sensor_reading_i;
          vbat_d    = battery_voltage_i;
        end
        OP_PHASE: begin
          err_d = $signed({1'b0, reading_q}) - $signed({1'b0, heater_target_q});
          case (phase_q)
            PH_PREHEAT: begin
              if (preheat_count_q < preheat_ticks_q) begin
                drive_d         = PREHEAT_DRIVE;
                preheat_count_d = preheat_count_q + 16'd1;
              end else begin
                preheat_count_d = '0;
                phase_d         = PH_RAMPUP;
                drive_d         = RAMP_START;
              end
            end
            PH_RAMPUP: begin
              if (drive_q > RAMP_END) begin
                phase_d = PH_HEATUP;
              end
              drive_d = drive_q + RAMP_STEP;
            end
            PH_HEATUP: begin
              if (reading_q < oper_threshold_q) begin
                phase_d = PH_OPER;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
        OP_ESUM: begin
          raw_sum_d    = {error_sum_q[15], error_sum_q} + {{4{err_q[12]}}, err_q};
          dif_d        = {err_q[12], err_q} - {prev_error_q[12], prev_error_q};
          prev_error_d = err_q;
        end
        OP_CLAMP: begin
          if (raw_sum_q > lim_pos) begin
            error_sum_d = lim_pos[15:0];
          end else if (raw_sum_q < lim_neg) begin
            error_sum_d = lim_neg[15:0];
          end else begin
            error_sum_d = raw_sum_q[15:0];
          end
          prod_d = mul_p;
        end
        OP_MULI: begin
          acc_d  = prod_q;
          prod_d = mul_p;
        end
        OP_MULD: begin
          acc_d  = acc_q + (prod_q >>> 1);
          prod_d = mul_p;
        end
        OP_SUM: begin
          acc_d = acc_q + prod_q;
        end
        OP_LIMIT: begin
          if (acc_q < 0) begin
            drive_d = '0;
          end else if (acc_q > drive_lim_ext) begin
            drive_d = drive_limit_q;
          end else begin
            drive_d = acc_q[14:0];
          end
        end
        OP_DUTYMUL: begin
          prod_d = mul_p;
        end
        OP_DIVINIT: begin
          num_d     = prod_q[30:0];
          rem_d     = '0;
          div_cnt_d = DIV_BITS;
        end
        OP_DIV: begin
          // restoring step: one quotient bit per cycle
          if (!div_trial[16]) begin
            rem_d = div_trial[14:0];
            num_d = {num_q[29:0], 1'b1};
          end else begin
            rem_d = {rem_q[13:0], num_q[30]};
            num_d = {num_q[29:0], 1'b0};
          end
          div_cnt_d = div_cnt_q - 5'd1;
        end
        OP_DUTY: begin
          if ((vbat_q == '0) || (num_q[30:16] != '0)) begin
            duty_d = '0;
          end else begin
            duty_d = DUTY_FULL - num_q[15:0];
          end
        end
        OP_OUT: begin
          phase_out_d = phase_q;
          drive_out_d = drive_q;
          duty_out_d  = duty_q;
          out_valid_d = 1'b1;
        end
        default: begin
          out_valid_d = out_valid_d;
        end
      endcase
    end
  end

  // Hold configuration; write at the addressed index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preheat_ticks_q  <= 16'd3000;
      oper_threshold_q <= 12'd1500;
      heater_target_q  <= 12'd1028;
      gain_p_q         <= 16'sd1;
      gain_i_q         <= 16'sd0;
      gain_d_q         <= 16'sd0;
      integral_limit_q <= 15'd32767;
      drive_limit_q    <= 15'd32767;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PREHEAT_TICKS:  preheat_ticks_q  <= cfg_wdata_i;
        REG_OPER_THRESHOLD: oper_threshold_q <= cfg_wdata_i[11:0];
        REG_HEATER_TARGET:  heater_target_q  <= cfg_wdata_i[11:0];
        REG_GAIN_P:         gain_p_q         <= cfg_wdata_i;
        REG_GAIN_I:         gain_i_q         <= cfg_wdata_i;
        REG_GAIN_D:         gain_d_q         <= cfg_wdata_i;
        REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_wdata_i[14:0];
        REG_DRIVE_LIMIT:    drive_limit_q    <= cfg_wdata_i[14:0];
        default:            preheat_ticks_q  <= preheat_ticks_q;
      endcase
    end
  end

  // Advance sequencer and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q            <= PC_WAIT;
      phase_q         <= PH_PREHEAT;
      preheat_count_q <= '0;
      drive_q         <= '0;
      error_sum_q     <= '0;
      prev_error_q    <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      pc_q            <= pc_d;
      phase_q         <= phase_d;
      preheat_count_q <= preheat_count_d;
      drive_q         <= drive_d;
      error_sum_q     <= error_sum_d;
      prev_error_q    <= prev_error_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // Update datapath working registers
  always_ff @(posedge clk_i) begin
    reading_q   <= reading_d;
    vbat_q      <= vbat_d;
    err_q       <= err_d;
    dif_q       <= dif_d;
    raw_sum_q   <= raw_sum_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    div_cnt_q   <= div_cnt_d;
    duty_q      <= duty_d;
    phase_out_q <= phase_out_d;
    drive_out_q <= drive_out_d;
    duty_out_q  <= duty_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign phase_o        = phase_out_q;
  assign heater_drive_o = drive_out_q;
  assign pwm_duty_o     = duty_out_q;

endmodule
